// ----- design/mtom_pkg.sv -----
`timescale 1ns / 1ps

package mtom_pkg;

  // Widths of the stream payloads, padded to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_INV_THERMAL_CURRENT = 2'd0,
    CFG_HEAT_GAIN           = 2'd1,
    CFG_END_GAIN            = 2'd2,
    CFG_COOLING_DECAY       = 2'd3
  } cfg_idx_e;

  // Register reset values
  localparam logic [31:0] InvThermalCurrentRst = 32'd4294967;
  localparam logic [23:0] HeatGainRst          = 24'd65536;
  localparam logic [23:0] EndGainRst           = 24'd6553600;
  localparam logic [15:0] CoolingDecayRst      = 16'd64880;

  // Fixed-point constants
  localparam logic [16:0] FactorOne    = 17'd65536;    // 1.0 in Q1.16
  localparam logic [31:0] CapTripLevel = 32'd6553600;  // 100.0 percent in Q16.16
  localparam logic [47:0] RatioOneProd = 48'h1_0000_0000;  // ratio 1.0 before the shift

endpackage

// ----- design/motor_thermal_overload_model.sv -----
`timescale 1ns / 1ps

// Motor thermal overload model.
// Input stream (s_axis_*): one item per evaluation period, carrying the three
// mean phase currents. Output stream (m_axis_*): one item per input item, with
// the trip flag, the thermal capacity used and the heating/cooling mode.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
// clock edge; write only while no item is in flight.
// Timing: one 32x32 multiplier is shared by every product of the period and
// a small sequencer steps it. The heating path takes one step more than the
// cooling path; s_axis_tready is low from acceptance until the result appears
// and is back high in the cycle the result appears, so the block takes no new
// item before it is through with the last one.
// The result sits in an output register: a stalled receiver does not stop
// the next item from being accepted and computed, but that item waits in its
// last step until the output register is free.
// Reset (rst_ni low, asynchronous): registers return to their defaults, the
// capacity clears to 0, the mode is heating and the decay factor is 1.0.
module motor_thermal_overload_model
  import mtom_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] phase_one_current, [31:16] phase_two_current,
  // [47:32] phase_three_current
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] tripped, [32:1] capacity_used, [33] cooling, [39:34] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_RATIO,
    ST_CHECK,
    ST_HEAT_SQ,
    ST_HEAT_EXC,
    ST_HEAT_LO,
    ST_HEAT_HI,
    ST_HEAT_ADD,
    ST_HEAT_SAT,
    ST_COOL_END,
    ST_COOL_FACT,
    ST_COOL_DIFF,
    ST_COOL_MUL,
    ST_COOL_RES,
    ST_DONE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [31:0] inv_current_q;
  logic [23:0] heat_gain_q;
  logic [23:0] end_gain_q;
  logic [15:0] cool_decay_q;

  // Thermal state
  logic [31:0] cap_q;
  logic [31:0] start_q;
  logic [16:0] factor_q;
  logic        mode_q;

  // Working registers of one period
  logic [15:0] max_q;
  logic [31:0] r_q;
  logic [47:0] exc_q;
  logic [55:0] acc_q;
  logic [31:0] end_q;
  logic [31:0] diff_q;
  logic        neg_q;
  logic        first_q;

  // Shared multiplier
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul_q;

  // Output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic        s_fire;
  logic        out_free;
  logic [15:0] in_max;
  logic [15:0] cur_one;
  logic [15:0] cur_two;
  logic [15:0] cur_three;
  logic [15:0] max_ab;
  logic [56:0] heat_sum;
  logic [32:0] cool_adj;
  logic [32:0] cool_res;

  assign cur_one   = s_axis_tdata[15:0];
  assign cur_two   = s_axis_tdata[31:16];
  assign cur_three = s_axis_tdata[47:32];
  assign max_ab    = (cur_two > cur_one) ? cur_two : cur_one;
  assign in_max    = (cur_three > max_ab) ? cur_three : max_ab;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Heating: capacity plus delta, saturated to 32 bits
  assign heat_sum = {25'd0, cap_q} + {1'b0, acc_q};

  // Cooling: end plus or minus (|start - end| * factor) >> 16
  assign cool_adj = mul_q[48:16];
  assign cool_res = neg_q ? ({1'b0, end_q} - cool_adj) : ({1'b0, end_q} + cool_adj);

  // Pick the multiplier operands for the current step
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_MUL_RATIO: begin
        op_a = {16'd0, max_q};
        op_b = inv_current_q;
      end
      ST_HEAT_SQ: begin
        op_a = r_q;
        op_b = r_q;
      end
      ST_HEAT_LO: begin
        op_a = {8'd0, heat_gain_q};
        op_b = exc_q[31:0];
      end
      ST_HEAT_HI: begin
        op_a = {8'd0, heat_gain_q};
        op_b = {16'd0, exc_q[47:32]};
      end
      ST_COOL_END: begin
        op_a = {8'd0, end_gain_q};
        op_b = r_q;
      end
      ST_COOL_FACT: begin
        op_a = {15'd0, factor_q};
        op_b = {16'd0, cool_decay_q};
      end
      ST_COOL_MUL: begin
        op_a = diff_q;
        op_b = {15'd0, factor_q};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Register every product; the next step consumes it
  always_ff @(posedge clk_i) begin
    mul_q <= 64'(op_a) * 64'(op_b);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_current_q <= InvThermalCurrentRst;
      heat_gain_q   <= HeatGainRst;
      end_gain_q    <= EndGainRst;
      cool_decay_q  <= CoolingDecayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INV_THERMAL_CURRENT: inv_current_q <= cfg_data_i;
        CFG_HEAT_GAIN:           heat_gain_q   <= cfg_data_i[23:0];
        CFG_END_GAIN:            end_gain_q    <= cfg_data_i[23:0];
        CFG_COOLING_DECAY:       cool_decay_q  <= cfg_data_i[15:0];
        default:                 inv_current_q <= inv_current_q;
      endcase
    end
  end

  // Working registers of the period: no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          max_q <= in_max;
        end
      end
      ST_CHECK: begin
        r_q <= mul_q[47:16];
      end
      ST_HEAT_EXC: begin
        exc_q <= mul_q[63:16] - 48'(FactorOne);
      end
      ST_HEAT_HI: begin
        // Low partial product, already shifted down
        acc_q <= {16'd0, mul_q[55:16]};
      end
      ST_HEAT_ADD: begin
        acc_q <= {mul_q[39:0], 16'd0} + acc_q;
      end
      ST_COOL_FACT: begin
        end_q   <= mul_q[47:16];
        first_q <= !mode_q;
      end
      ST_COOL_DIFF: begin
        neg_q  <= (start_q < end_q);
        diff_q <= (start_q < end_q) ? (end_q - start_q) : (start_q - end_q);
      end
      default: begin
        max_q <= max_q;
      end
    endcase
  end

  // Sequencer, thermal state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= '0;
      start_q     <= '0;
      factor_q    <= FactorOne;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            state_q <= ST_MUL_RATIO;
          end
        end
        ST_MUL_RATIO: state_q <= ST_CHECK;
        ST_CHECK: begin
          // Heat while the ratio is strictly above one
          state_q <= (mul_q[47:0] > RatioOneProd) ? ST_HEAT_SQ : ST_COOL_END;
        end
        ST_HEAT_SQ: begin
          // Any heating period ends the cooling phase
          mode_q  <= 1'b0;
          state_q <= ST_HEAT_EXC;
        end
        ST_HEAT_EXC: state_q <= ST_HEAT_LO;
        ST_HEAT_LO:  state_q <= ST_HEAT_HI;
        ST_HEAT_HI:  state_q <= ST_HEAT_ADD;
        ST_HEAT_ADD: state_q <= ST_HEAT_SAT;
        ST_HEAT_SAT: begin
          cap_q   <= (|heat_sum[56:32]) ? '1 : heat_sum[31:0];
          state_q <= ST_DONE;
        end
        ST_COOL_END: state_q <= ST_COOL_FACT;
        ST_COOL_FACT: begin
          // First cooling period: latch the start and restart the factor
          if (!mode_q) begin
            mode_q   <= 1'b1;
            start_q  <= cap_q;
            factor_q <= FactorOne;
          end
          state_q <= ST_COOL_DIFF;
        end
        ST_COOL_DIFF: begin
          if (!first_q) begin
            factor_q <= mul_q[32:16];
          end
          state_q <= ST_COOL_MUL;
        end
        ST_COOL_MUL: state_q <= ST_COOL_RES;
        ST_COOL_RES: begin
          cap_q   <= cool_res[31:0];
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {6'd0, mode_q, cap_q, (cap_q > CapTripLevel)};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // One item at a time: no second item right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("input accepted while a period is in progress");

  // The decay factor never rises above one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    factor_q <= FactorOne)
    else $error("decay factor above one");

  // A heating period never lowers the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HEAT_SAT) |=> (cap_q >= $past(cap_q)))
    else $error("capacity dropped while heating");

  // A result is loaded only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !m_axis_tready) |=> (state_q == ST_DONE))
    else $error("result overwrote a pending output item");
`endif

endmodule
